### rtl/kts_pkg.sv
// Shared types and constants for the keyframe track sampler.
`default_nettype none
package kts_pkg;

    localparam int SLOT_W  = 8;
    localparam int PTR_W   = SLOT_W + 1;
    localparam int FRAME_W = 16;
    localparam int VAL_W   = 24;
    localparam int TIME_W  = 24;
    localparam int MODE_W  = 2;
    localparam int NCOMP   = 3;
    localparam int COMP_W  = 2;
    localparam int FRAC_W  = 16;
    localparam int QUO_W   = FRAC_W + 1;
    localparam int CNT_W   = 5;
    localparam int PROD_W  = (VAL_W + 1) + (QUO_W + 1);

    localparam logic [VAL_W-1:0]  ONE_Q16  = VAL_W'(1 << FRAC_W);
    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1 << (FRAC_W - 1));

    // Request kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Track modes; the unused code behaves as step
    localparam logic [MODE_W-1:0] MODE_LIN3 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LIN1 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEP = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic              accept;
        logic              wr;
        logic              ptr_inc;
        logic              take_prev;
        logic              div_init;
        logic              div_step;
        logic              mul;
        logic              acc;
        logic [COMP_W-1:0] comp;
        logic              ld_default;
        logic              ld_prev;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic step;
        logic le_q;
        logic lt_q;
        logic ptr_lt_end;
    } t_stat;

endpackage
`default_nettype wire

### rtl/kts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kts_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/kts_dp.sv
// Datapath: key store, search registers, serial divider and interpolation MAC.
`default_nettype none
module kts_dp #(
    parameter int KEY_SLOTS = 256
) (
    input  wire logic                          i_clk,
    input  wire kts_pkg::t_cmd                 i_cmd,
    input  wire logic [kts_pkg::SLOT_W-1:0]    i_slot,
    input  wire logic [kts_pkg::FRAME_W-1:0]   i_key_frame,
    input  wire logic signed [kts_pkg::VAL_W-1:0] i_value_x,
    input  wire logic signed [kts_pkg::VAL_W-1:0] i_value_y,
    input  wire logic signed [kts_pkg::VAL_W-1:0] i_value_z,
    input  wire logic [kts_pkg::SLOT_W-1:0]    i_track_start,
    input  wire logic [kts_pkg::SLOT_W-1:0]    i_track_end,
    input  wire logic [kts_pkg::TIME_W-1:0]    i_query_time,
    input  wire logic [kts_pkg::MODE_W-1:0]    i_mode,
    output kts_pkg::t_stat                     o_stat,
    output logic signed [kts_pkg::VAL_W-1:0]   o_out_x,
    output logic signed [kts_pkg::VAL_W-1:0]   o_out_y,
    output logic signed [kts_pkg::VAL_W-1:0]   o_out_z
);
    import kts_pkg::*;

    localparam int IDX_W  = $clog2(KEY_SLOTS);
    localparam int WORD_W = FRAME_W + NCOMP * VAL_W;
    localparam logic [PTR_W-1:0] SLOTS_P = PTR_W'(KEY_SLOTS);

    logic [PTR_W-1:0]  start_c, end_c;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [FRAME_W-1:0] rd_frame;
    logic [TIME_W-1:0] rd_time;
    logic signed [VAL_W-1:0] rd_val [NCOMP];

    logic [PTR_W-1:0]  r_start, r_end, r_ptr;
    logic [TIME_W-1:0] r_q;
    logic [MODE_W-1:0] r_mode;
    logic [TIME_W-1:0] r_prev_time;
    logic signed [VAL_W-1:0] r_prev_val [NCOMP];
    logic signed [VAL_W-1:0] r_cur_val [NCOMP];
    logic [TIME_W:0]   r_rem;
    logic [TIME_W-1:0] r_div;
    logic [QUO_W-1:0]  r_quo;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VAL_W-1:0]  r_out [NCOMP];

    logic              scalar;
    logic              div_ge;
    logic [TIME_W:0]   div_diff;
    logic signed [VAL_W:0]    delta;
    logic signed [QUO_W:0]    quo_s;
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] shifted;
    logic signed [VAL_W-1:0]  interp;

    // Clamp track bounds to the store size
    assign start_c = ({1'b0, i_track_start} > SLOTS_P) ? SLOTS_P : {1'b0, i_track_start};
    assign end_c   = ({1'b0, i_track_end} > SLOTS_P) ? SLOTS_P : {1'b0, i_track_end};

    // Key store: frame on top, then z, y, x
    assign ram_we    = i_cmd.wr && ({1'b0, i_slot} < SLOTS_P);
    assign ram_wdata = {i_key_frame, i_value_z, i_value_y, i_value_x};
    assign ram_raddr = i_cmd.accept ? start_c[IDX_W-1:0] : r_ptr[IDX_W-1:0];

    kts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (KEY_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_slot[IDX_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Unpack read word; frame number becomes Q16.8 time
    assign rd_frame = ram_rdata[WORD_W-1 -: FRAME_W];
    assign rd_time  = {rd_frame, {(TIME_W - FRAME_W){1'b0}}};
    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            rd_val[c] = ram_rdata[c*VAL_W +: VAL_W];
        end
    end

    // Status for the controller
    assign scalar            = (r_mode != MODE_LIN3);
    assign o_stat.empty      = (r_start >= r_end);
    assign o_stat.step       = (r_mode >= MODE_STEP);
    assign o_stat.le_q       = (rd_time <= r_q);
    assign o_stat.lt_q       = (rd_time < r_q);
    assign o_stat.ptr_lt_end = (r_ptr < r_end);

    // Restoring divide step, one quotient bit per cycle
    assign div_ge   = (r_rem >= {1'b0, r_div});
    assign div_diff = div_ge ? (r_rem - {1'b0, r_div}) : r_rem;

    // Component delta times fraction, then round half up and add base
    assign delta   = (VAL_W+1)'(r_cur_val[i_cmd.comp]) - (VAL_W+1)'(r_prev_val[i_cmd.comp]);
    assign quo_s   = $signed({1'b0, r_quo});
    assign rnd     = r_prod + $signed(RND_HALF);
    assign shifted = rnd >>> FRAC_W;
    assign interp  = r_prev_val[i_cmd.comp] + shifted[VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        // Request capture
        if (i_cmd.accept) begin
            r_start <= start_c;
            r_end   <= end_c;
            r_q     <= i_query_time;
            r_mode  <= i_mode;
            r_ptr   <= start_c + PTR_W'(1);
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + PTR_W'(1);
        end

        // Bracketing keys
        if (i_cmd.take_prev) begin
            r_prev_time <= rd_time;
            for (int c = 0; c < NCOMP; c++) begin
                r_prev_val[c] <= rd_val[c];
            end
        end
        if (i_cmd.div_init) begin
            for (int c = 0; c < NCOMP; c++) begin
                r_cur_val[c] <= rd_val[c];
            end
            r_rem <= {1'b0, r_q - r_prev_time};
            r_div <= rd_time - r_prev_time;
        end else if (i_cmd.div_step) begin
            r_rem <= {div_diff[TIME_W-1:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], div_ge};
        end

        // Shared multiplier
        if (i_cmd.mul) begin
            r_prod <= delta * quo_s;
        end

        // Result registers
        if (i_cmd.ld_default) begin
            r_out[0] <= scalar ? ONE_Q16 : '0;
            for (int c = 1; c < NCOMP; c++) begin
                r_out[c] <= '0;
            end
        end else if (i_cmd.ld_prev) begin
            r_out[0] <= r_prev_val[0];
            for (int c = 1; c < NCOMP; c++) begin
                r_out[c] <= scalar ? '0 : r_prev_val[c];
            end
        end else if (i_cmd.acc) begin
            r_out[i_cmd.comp] <= (scalar && (i_cmd.comp != '0)) ? '0 : interp;
        end
    end

    assign o_out_x = r_out[0];
    assign o_out_y = r_out[1];
    assign o_out_z = r_out[2];

endmodule
`default_nettype wire

### rtl/kts_ctrl.sv
// Controller: sequences key search, divide and interpolation for each request.
`default_nettype none
module kts_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_kind,
    input  wire kts_pkg::t_stat i_stat,
    output kts_pkg::t_cmd       o_cmd,
    output logic                o_busy,
    output logic                o_valid
);
    import kts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_SCAN,
        S_DIV,
        S_MUL,
        S_ACC,
        S_OUTP
    } t_state;

    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(QUO_W - 1);
    localparam logic [COMP_W-1:0] COMP_LAST = COMP_W'(NCOMP - 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [COMP_W-1:0]  r_comp, n_comp;
    logic               r_valid, n_valid;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_comp  = r_comp;
        n_valid = 1'b0;
        o_cmd   = '0;
        o_cmd.comp = r_comp;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_kind == KIND_SAMPLE) begin
                        o_cmd.accept = 1'b1;
                        n_state      = S_FIRST;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_FIRST: begin
                if (i_stat.empty) begin
                    o_cmd.ld_default = 1'b1;
                    n_valid          = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.take_prev = 1'b1;
                    if (!i_stat.ptr_lt_end || !i_stat.lt_q) begin
                        n_state = S_OUTP;
                    end else begin
                        o_cmd.ptr_inc = 1'b1;
                        n_state       = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.step ? i_stat.le_q : i_stat.lt_q) begin
                    // key reached; keep scanning while keys remain
                    o_cmd.take_prev = 1'b1;
                    if (i_stat.ptr_lt_end) begin
                        o_cmd.ptr_inc = 1'b1;
                    end else begin
                        n_state = S_OUTP;
                    end
                end else if (i_stat.step) begin
                    n_state = S_OUTP;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    n_comp  = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_comp == COMP_LAST) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_comp  = r_comp + COMP_W'(1);
                    n_state = S_MUL;
                end
            end
            S_OUTP: begin
                o_cmd.ld_prev = 1'b1;
                n_valid       = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_comp  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule
`default_nettype wire

### rtl/keyframe_track_sampler.sv
// Keyframe track sampler top level: keyframe store with linear and step sampling.
// Write request: taken only while idle, busy stays low, no result.
// Sample request: busy drops as the result strobe rises; an empty track gives a default result,
//   otherwise the held key value or, when interpolating, the value between two keys.
// The key scan reads one slot per cycle from the store; interpolation adds a bit-serial divide
//   and per-component products on one shared multiplier. Next request may start on the strobe.
// Reset is synchronous and clears control only; the key store holds no reset value.
`default_nettype none
module keyframe_track_sampler #(
    parameter int KEY_SLOTS = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_kind,
    input  wire logic [kts_pkg::SLOT_W-1:0]       i_slot,
    input  wire logic [kts_pkg::FRAME_W-1:0]      i_key_frame,
    input  wire logic signed [kts_pkg::VAL_W-1:0] i_value_x,
    input  wire logic signed [kts_pkg::VAL_W-1:0] i_value_y,
    input  wire logic signed [kts_pkg::VAL_W-1:0] i_value_z,
    input  wire logic [kts_pkg::SLOT_W-1:0]       i_track_start,
    input  wire logic [kts_pkg::SLOT_W-1:0]       i_track_end,
    input  wire logic [kts_pkg::TIME_W-1:0]       i_query_time,
    input  wire logic [kts_pkg::MODE_W-1:0]       i_mode,
    output logic                                  o_valid,
    output logic signed [kts_pkg::VAL_W-1:0]      o_out_x,
    output logic signed [kts_pkg::VAL_W-1:0]      o_out_y,
    output logic signed [kts_pkg::VAL_W-1:0]      o_out_z
);
    import kts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    kts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // Store and arithmetic
    kts_dp #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_slot        (i_slot),
        .i_key_frame   (i_key_frame),
        .i_value_x     (i_value_x),
        .i_value_y     (i_value_y),
        .i_value_z     (i_value_z),
        .i_track_start (i_track_start),
        .i_track_end   (i_track_end),
        .i_query_time  (i_query_time),
        .i_mode        (i_mode),
        .o_stat        (stat),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z)
    );

endmodule
`default_nettype wire

### rtl/kts_checker.sv
// Port-level checks for the keyframe track sampler, bound to the top level.
`default_nettype none
module kts_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_kind,
    input wire logic o_valid
);
    import kts_pkg::*;

    // A result strobe lasts exactly one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // An accepted sample request makes the block busy
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_SAMPLE)) |=> busy)
        else $error("sample request accepted without going busy");

    // A write request causes no result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_WRITE)) |=> (!o_valid && !busy))
        else $error("write request produced a result or busy");

    // Busy only drops together with a delivered result
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_kind  (i_kind),
    .o_valid (o_valid)
);
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the keyframe track sampler: keyframe writes and track sampling.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kts_pkg::*;

    localparam int SLOTS       = 256;
    localparam int LIMIT       = 1_000_000;
    localparam int TAIL_CYCLES = 300;
    localparam int MAX_REPORTS = 100;
    localparam int MAX_GAP     = 40;
    // Spare mode code, behaves as step
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic                kind;
        logic [SLOT_W-1:0]   slot;
        logic [FRAME_W-1:0]  frame;
        logic [VAL_W-1:0]    vx;
        logic [VAL_W-1:0]    vy;
        logic [VAL_W-1:0]    vz;
        logic [SLOT_W-1:0]   ts;
        logic [SLOT_W-1:0]   te;
        logic [TIME_W-1:0]   qt;
        logic [MODE_W-1:0]   md;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        logic [VAL_W-1:0] z;
    } t_triple;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_kind = 1'b0;
    logic [SLOT_W-1:0]         i_slot = '0;
    logic [FRAME_W-1:0]        i_key_frame = '0;
    logic signed [VAL_W-1:0]   i_value_x = '0;
    logic signed [VAL_W-1:0]   i_value_y = '0;
    logic signed [VAL_W-1:0]   i_value_z = '0;
    logic [SLOT_W-1:0]         i_track_start = '0;
    logic [SLOT_W-1:0]         i_track_end = '0;
    logic [TIME_W-1:0]         i_query_time = '0;
    logic [MODE_W-1:0]         i_mode = '0;
    logic                      o_valid;
    logic signed [VAL_W-1:0]   o_out_x;
    logic signed [VAL_W-1:0]   o_out_y;
    logic signed [VAL_W-1:0]   o_out_z;

    // Shadow keyframe store and the samples still owed by the block
    logic [FRAME_W-1:0]        key_frm [SLOTS];
    logic signed [VAL_W-1:0]   key_val [SLOTS][NCOMP];
    t_triple                   want_q [$];

    int n_fail = 0;
    int n_sent = 0;
    int idle_pct = 0;
    int cyc = 0;

    keyframe_track_sampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_slot        (i_slot),
        .i_key_frame   (i_key_frame),
        .i_value_x     (i_value_x),
        .i_value_y     (i_value_y),
        .i_value_z     (i_value_z),
        .i_track_start (i_track_start),
        .i_track_end   (i_track_end),
        .i_query_time  (i_query_time),
        .i_mode        (i_mode),
        .o_valid       (o_valid),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Key time in Q16.8 frames
    function automatic logic [TIME_W-1:0] key_time(input int k);
        return {key_frm[k], 8'h00};
    endfunction

    // Value of track [s, e) at time qt
    function automatic t_triple sample_track(input int s, input int e,
                                             input logic [TIME_W-1:0] qt,
                                             input logic [MODE_W-1:0] md);
        int k;
        int hold;
        int ncomp;
        logic [TIME_W-1:0] tj;
        logic [TIME_W-1:0] tk;
        longint unsigned num;
        longint unsigned den;
        longint unsigned frac;
        longint vj;
        longint d;
        longint acc;
        logic [VAL_W-1:0] outc [NCOMP];
        t_triple res;
        outc = '{default: '0};
        ncomp = (md == MODE_LIN3) ? NCOMP : 1;
        hold = -1;
        if (s >= e) begin
            if (md != MODE_LIN3) outc[0] = ONE_Q16;
        end else if (s + 1 == e || qt <= key_time(s)) begin
            hold = s;
        end else if (md != MODE_LIN3 && md != MODE_LIN1) begin
            // step: last key at or before the query
            k = s;
            while (k + 1 < e && key_time(k + 1) <= qt) k++;
            hold = k;
        end else begin
            // first later key at or past the query
            k = s + 1;
            while (k < e && key_time(k) < qt) k++;
            if (k >= e) begin
                hold = e - 1;
            end else begin
                tj = key_time(k - 1);
                tk = key_time(k);
                num = 64'(qt - tj);
                den = 64'(tk - tj);
                frac = (num << 16) / den;
                for (int c = 0; c < ncomp; c++) begin
                    vj = longint'(key_val[k - 1][c]);
                    d = longint'(key_val[k][c]) - vj;
                    // round half up, floor on negatives
                    acc = vj + ((d * longint'(frac) + 32768) >>> 16);
                    outc[c] = acc[VAL_W-1:0];
                end
            end
        end
        if (hold >= 0) begin
            for (int c = 0; c < ncomp; c++) outc[c] = key_val[hold][c];
        end
        res.x = outc[0];
        res.y = outc[1];
        res.z = outc[2];
        return res;
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.kind  = 1'($urandom);
        r.slot  = SLOT_W'($urandom);
        r.frame = FRAME_W'($urandom);
        r.vx    = VAL_W'($urandom);
        r.vy    = VAL_W'($urandom);
        r.vz    = VAL_W'($urandom);
        r.ts    = SLOT_W'($urandom);
        r.te    = SLOT_W'($urandom);
        r.qt    = TIME_W'($urandom);
        r.md    = MODE_W'($urandom);
        return r;
    endfunction

    // Present one request and track it once the block takes it
    task automatic send_req(input t_req r);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_kind        <= r.kind;
        i_slot        <= r.slot;
        i_key_frame   <= r.frame;
        i_value_x     <= r.vx;
        i_value_y     <= r.vy;
        i_value_z     <= r.vz;
        i_track_start <= r.ts;
        i_track_end   <= r.te;
        i_query_time  <= r.qt;
        i_mode        <= r.md;
        do @(posedge i_clk); while (busy !== 1'b0);
        n_sent++;
        if (r.kind == KIND_WRITE) begin
            key_frm[r.slot]    = r.frame;
            key_val[r.slot][0] = r.vx;
            key_val[r.slot][1] = r.vy;
            key_val[r.slot][2] = r.vz;
        end else begin
            want_q.push_back(sample_track(int'(r.ts), int'(r.te), r.qt, r.md));
        end
    endtask

    task automatic put_key(input int slot, input int frame,
                           input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y,
                           input logic [VAL_W-1:0] z);
        t_req r;
        r = rand_req();
        r.kind  = KIND_WRITE;
        r.slot  = SLOT_W'(slot);
        r.frame = FRAME_W'(frame);
        r.vx    = x;
        r.vy    = y;
        r.vz    = z;
        send_req(r);
    endtask

    task automatic query_track(input int ts, input int te, input logic [TIME_W-1:0] qt,
                               input logic [MODE_W-1:0] md);
        t_req r;
        r = rand_req();
        r.kind = KIND_SAMPLE;
        r.ts   = SLOT_W'(ts);
        r.te   = SLOT_W'(te);
        r.qt   = qt;
        r.md   = md;
        send_req(r);
    endtask

    // Hold off until every owed sample is back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (want_q.size() != 0) @(posedge i_clk);
    endtask

    // Query time near a track's key range, sometimes on a key or anywhere
    function automatic logic [TIME_W-1:0] pick_time(input int f_first, input int f_last);
        int lo;
        int hi;
        int sel;
        lo = f_first * 256 - 600;
        hi = f_last * 256 + 600;
        if (lo < 0) lo = 0;
        if (hi > 24'hFF_FFFF) hi = 24'hFF_FFFF;
        sel = $urandom_range(9);
        if (sel == 0) return TIME_W'($urandom);
        if (sel == 1) return TIME_W'(($urandom_range(1) != 0) ? f_last * 256 : f_first * 256);
        return TIME_W'($urandom_range(hi, lo));
    endfunction

    // Every slot gets an ascending key so any range may be sampled
    task automatic test_fill_store();
        for (int i = 0; i < SLOTS; i++) begin
            put_key(i, i * 256 + ((i == SLOTS - 1) ? 255 : 0),
                    VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
        end
    endtask

    task automatic test_corner_cases();
        // empty and reversed tracks, every mode
        query_track(20, 20, TIME_W'($urandom), MODE_LIN3);
        query_track(20, 20, TIME_W'($urandom), MODE_LIN1);
        query_track(200, 100, TIME_W'($urandom), MODE_STEP);
        query_track(255, 255, TIME_W'($urandom), MODE_SPARE);
        // extreme values, a repeated frame and the top frame
        put_key(10, 0, 24'h80_0000, 24'h7F_FFFF, 24'h00_0000);
        put_key(11, 100, 24'h7F_FFFF, 24'h80_0000, 24'hFF_FFFF);
        put_key(12, 100, 24'h00_0000, 24'h00_0001, 24'h80_0000);
        put_key(13, 65535, VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
        // single key, query at or before the first key
        query_track(10, 11, 24'hFF_FFFF, MODE_LIN3);
        query_track(11, 14, TIME_W'(100 * 256), MODE_LIN3);
        query_track(10, 14, TIME_W'(0), MODE_LIN1);
        // interpolation across the full value range
        query_track(10, 14, TIME_W'(50 * 256), MODE_LIN3);
        query_track(10, 14, TIME_W'(50 * 256 + 1), MODE_LIN1);
        // exactly on a key, then past the repeated frame
        query_track(10, 14, TIME_W'(100 * 256), MODE_LIN3);
        query_track(10, 14, TIME_W'(100 * 256 + 128), MODE_LIN3);
        // past the last key clamps, then step and spare modes
        query_track(10, 14, 24'hFF_FFFF, MODE_LIN3);
        query_track(10, 14, TIME_W'(100 * 256), MODE_STEP);
        query_track(10, 14, 24'hFF_FFFF, MODE_STEP);
        query_track(10, 14, TIME_W'(50 * 256), MODE_SPARE);
        // longest track the fields allow
        query_track(0, 255, 24'hFF_FFFF, MODE_LIN1);
        query_track(0, 255, TIME_W'($urandom), MODE_LIN3);
    endtask

    task automatic test_random_traffic(input int n_items, input int pct);
        int stop_at;
        int sel;
        int len;
        int s;
        int ts;
        int te;
        int f;
        int f_first;
        int n_q;
        stop_at = n_sent + n_items;
        idle_pct = pct;
        while (n_sent < stop_at) begin
            sel = $urandom_range(99);
            if ($urandom_range(39) == 0) drain();
            if (sel < 55) begin
                // program a well-formed track, then sample it
                len = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
                s = $urandom_range(255 - len);
                f = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(4000);
                f_first = f;
                for (int i = 0; i < len; i++) begin
                    put_key(s + i, f, VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
                    f += ($urandom_range(7) == 0) ? 0 : $urandom_range(400, 1);
                    if (f > 65535) f = 65535;
                end
                n_q = $urandom_range(4, 1);
                for (int i = 0; i < n_q; i++) begin
                    ts = s;
                    te = s + len;
                    if ($urandom_range(3) == 0) begin
                        ts = $urandom_range(s + len - 1, s);
                        te = $urandom_range(s + len, ts + 1);
                    end
                    query_track(ts, te, pick_time(int'(key_frm[ts]), int'(key_frm[te - 1])),
                                MODE_W'($urandom));
                end
            end else if (sel < 85) begin
                // any range over the filled store
                ts = $urandom_range(255);
                if ($urandom_range(2) == 0) begin
                    te = $urandom_range(255);
                end else begin
                    te = ts + $urandom_range(6);
                    if (te > 255) te = 255;
                end
                query_track(ts, te, pick_time(int'(key_frm[ts]), int'(key_frm[ts]) + 2000),
                            MODE_W'($urandom));
            end else begin
                // stray key anywhere, order not kept
                put_key($urandom_range(255), $urandom_range(65535),
                        VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
            end
        end
        drain();
    endtask

    function automatic void check_comp(input string name, input logic [VAL_W-1:0] want,
                                       input logic [VAL_W-1:0] got);
        if (got !== want) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS) begin
                $display("%0t: %s expected %06h actual %06h", $time, name, want, got);
            end
        end
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_triple want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (want_q.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS) begin
                    $display("%0t: result expected none actual %06h %06h %06h",
                             $time, o_out_x, o_out_y, o_out_z);
                end
            end else begin
                want = want_q.pop_front();
                check_comp("out_x", want.x, o_out_x);
                check_comp("out_y", want.y, o_out_y);
                check_comp("out_z", want.z, o_out_z);
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 0;
        test_fill_store();
        test_corner_cases();
        drain();
        test_random_traffic(75, 0);
        test_random_traffic(75, 73);
        test_random_traffic(75, 11);
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire
